// ----- src/gpio_pkg.sv -----
// gpio_pkg: shared types, register indexes and the command decode of the gpio port
// no dependencies; compiled first
package gpio_pkg;

  localparam int unsigned PORT_W = 32;
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned IDX_W  = 5;

  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

  localparam logic [IDX_W-1:0] R_PIN    = 5'd0;
  localparam logic [IDX_W-1:0] R_INT    = 5'd1;
  localparam logic [IDX_W-1:0] R_INTS   = 5'd2;
  localparam logic [IDX_W-1:0] R_INTC   = 5'd3;
  localparam logic [IDX_W-1:0] R_MASK   = 5'd4;
  localparam logic [IDX_W-1:0] R_MASKS  = 5'd5;
  localparam logic [IDX_W-1:0] R_MASKC  = 5'd6;
  localparam logic [IDX_W-1:0] R_PAT1   = 5'd7;
  localparam logic [IDX_W-1:0] R_PAT1S  = 5'd8;
  localparam logic [IDX_W-1:0] R_PAT1C  = 5'd9;
  localparam logic [IDX_W-1:0] R_PAT0   = 5'd10;
  localparam logic [IDX_W-1:0] R_PAT0S  = 5'd11;
  localparam logic [IDX_W-1:0] R_PAT0C  = 5'd12;
  localparam logic [IDX_W-1:0] R_FLAG   = 5'd13;
  localparam logic [IDX_W-1:0] R_FLAGC  = 5'd14;
  localparam logic [IDX_W-1:0] R_DPULL  = 5'd15;
  localparam logic [IDX_W-1:0] R_DPULLS = 5'd16;
  localparam logic [IDX_W-1:0] R_DPULLC = 5'd17;

  typedef enum logic [1:0] {
    K_NONE,
    K_WRITE,
    K_SET,
    K_CLEAR
  } kind_e;

  typedef enum logic [2:0] {
    RD_NONE,
    RD_PIN,
    RD_INT,
    RD_MASK,
    RD_PAT1,
    RD_PAT0,
    RD_FLAG,
    RD_DPULL
  } rd_sel_e;

  // per-word control shared by all lanes
  typedef struct packed {
    kind_e   int_k;
    kind_e   mask_k;
    kind_e   pat1_k;
    kind_e   pat0_k;
    kind_e   dpull_k;
    logic    flag_clr;
    logic    tick;
    rd_sel_e rd_sel;
  } gpio_ctl_t;

  // register bits of one pin
  typedef struct packed {
    logic lvl;
    logic intr;
    logic mask;
    logic pat1;
    logic pat0;
    logic flag;
    logic dpull;
  } gpio_bits_t;

  // outputs of one pin after the update
  typedef struct packed {
    logic drv_val;
    logic drv_en;
    logic pull_en;
    logic irq;
  } gpio_pin_t;

  function automatic logic apply_bit(input logic cur, input logic d, input kind_e k);
    logic r;
    unique case (k)
      K_NONE:  r = cur;
      K_WRITE: r = d;
      K_SET:   r = cur | d;
      K_CLEAR: r = cur & ~d;
    endcase
    return r;
  endfunction

  function automatic gpio_ctl_t decode(input logic [CMD_W-1:0] cmd,
                                       input logic [IDX_W-1:0] idx);
    gpio_ctl_t c;
    c = '0;
    unique case (cmd)
      CMD_WRITE: begin
        case (idx)
          R_INT:    c.int_k    = K_WRITE;
          R_INTS:   c.int_k    = K_SET;
          R_INTC:   c.int_k    = K_CLEAR;
          R_MASK:   c.mask_k   = K_WRITE;
          R_MASKS:  c.mask_k   = K_SET;
          R_MASKC:  c.mask_k   = K_CLEAR;
          R_PAT1:   c.pat1_k   = K_WRITE;
          R_PAT1S:  c.pat1_k   = K_SET;
          R_PAT1C:  c.pat1_k   = K_CLEAR;
          R_PAT0:   c.pat0_k   = K_WRITE;
          R_PAT0S:  c.pat0_k   = K_SET;
          R_PAT0C:  c.pat0_k   = K_CLEAR;
          R_FLAGC:  c.flag_clr = 1'b1;
          R_DPULL:  c.dpull_k  = K_WRITE;
          R_DPULLS: c.dpull_k  = K_SET;
          R_DPULLC: c.dpull_k  = K_CLEAR;
          default:  ;
        endcase
      end
      CMD_READ: begin
        case (idx)
          R_PIN:   c.rd_sel = RD_PIN;
          R_INT:   c.rd_sel = RD_INT;
          R_MASK:  c.rd_sel = RD_MASK;
          R_PAT1:  c.rd_sel = RD_PAT1;
          R_PAT0:  c.rd_sel = RD_PAT0;
          R_FLAG:  c.rd_sel = RD_FLAG;
          R_DPULL: c.rd_sel = RD_DPULL;
          default: ;
        endcase
      end
      CMD_TICK: c.tick = 1'b1;
      default:  ;
    endcase
    return c;
  endfunction

endpackage

// ----- src/gpio_req_if.sv -----
// gpio_req_if: request channel of the gpio port (bus access or pin sample tick)
// depends on gpio_pkg
interface gpio_req_if;
  import gpio_pkg::*;

  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [IDX_W-1:0]    reg_index;
  logic [PORT_W-1:0]   write_data;
  logic [PORT_W-1:0]   pin_levels;

  modport source (output valid, cmd, reg_index, write_data, pin_levels, input ready);
  modport sink   (input valid, cmd, reg_index, write_data, pin_levels, output ready);
endinterface

// ----- src/gpio_rsp_if.sv -----
// gpio_rsp_if: result channel of the gpio port (read data, pin drive state, irq)
// depends on gpio_pkg
interface gpio_rsp_if;
  import gpio_pkg::*;

  logic              valid;
  logic              ready;
  logic [PORT_W-1:0] read_data;
  logic [PORT_W-1:0] drive_value;
  logic [PORT_W-1:0] drive_enable;
  logic [PORT_W-1:0] pull_enable;
  logic              irq;

  modport source (output valid, read_data, drive_value, drive_enable, pull_enable, irq,
                  input ready);
  modport sink   (input valid, read_data, drive_value, drive_enable, pull_enable, irq,
                  output ready);
endinterface

// ----- src/gpio_port_set_clear_irq.sv -----
// gpio_port_set_clear_irq: gpio port with set/clear aliases and pin interrupts.
// a result word is valid in the cycle after its request word is accepted.
// throughput: one word per cycle; a single output register holds the result and
//   the request side keeps accepting whenever that register is empty or being taken.
// reset: INT, PAT0, FLAG, DPULL and pin history clear, MASK and PAT1 set, no result held.
// depends on gpio_pkg, gpio_req_if, gpio_rsp_if, gpio_lane, gpio_merge
module gpio_port_set_clear_irq #(
  parameter int unsigned NUM_PINS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  gpio_req_if.sink   req_i,
  gpio_rsp_if.source rsp_o
);
  import gpio_pkg::*;

  gpio_ctl_t  ctl;
  logic       acc;
  logic       ready;
  gpio_bits_t cur [NUM_PINS];
  gpio_pin_t  pin [NUM_PINS];

  assign ctl         = decode(req_i.cmd, req_i.reg_index);
  assign req_i.ready = ready;
  assign acc         = req_i.valid & ready;

  for (genvar g = 0; g < NUM_PINS; g++) begin : g_lane
    gpio_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (acc),
      .ctl_i   (ctl),
      .wdata_i (req_i.write_data[g]),
      .level_i (req_i.pin_levels[g]),
      .cur_o   (cur[g]),
      .pin_o   (pin[g])
    );
  end

  gpio_merge #(
    .NUM_PINS (NUM_PINS)
  ) u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .acc_i    (acc),
    .rd_sel_i (ctl.rd_sel),
    .cur_i    (cur),
    .pin_i    (pin),
    .ready_o  (ready),
    .rsp_o    (rsp_o)
  );

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> rsp_o.valid)
    else $error("accepted word produced no result");

  a_write_reads_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && req_i.cmd == CMD_WRITE |=> rsp_o.read_data == '0)
    else $error("write returned nonzero read data");

  a_alias_reads_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && req_i.cmd == CMD_READ && req_i.reg_index == R_FLAGC |=> rsp_o.read_data == '0)
    else $error("flag clear alias read nonzero");

  a_drive_gated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (rsp_o.drive_value & ~rsp_o.drive_enable) == '0)
    else $error("drive value on an undriven pin");

endmodule

// ----- src/gpio_lane.sv -----
// gpio_lane: register bits, set/clear update and event detection of one pin
// depends on gpio_pkg
module gpio_lane (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  gpio_pkg::gpio_ctl_t ctl_i,
  input  logic                wdata_i,
  input  logic                level_i,
  output gpio_pkg::gpio_bits_t cur_o,
  output gpio_pkg::gpio_pin_t  pin_o
);
  import gpio_pkg::*;

  gpio_bits_t bits_q, bits_d;
  logic       rise, fall, edge_hit, level_hit, hit;

  always_comb begin
    rise      = level_i & ~bits_q.lvl;
    fall      = ~level_i & bits_q.lvl;
    edge_hit  = bits_q.pat0 ? rise : fall;
    level_hit = bits_q.pat0 ? level_i : ~level_i;
    hit       = bits_q.pat1 ? edge_hit : level_hit;

    bits_d       = bits_q;
    bits_d.intr  = apply_bit(bits_q.intr,  wdata_i, ctl_i.int_k);
    bits_d.mask  = apply_bit(bits_q.mask,  wdata_i, ctl_i.mask_k);
    bits_d.pat1  = apply_bit(bits_q.pat1,  wdata_i, ctl_i.pat1_k);
    bits_d.pat0  = apply_bit(bits_q.pat0,  wdata_i, ctl_i.pat0_k);
    bits_d.dpull = apply_bit(bits_q.dpull, wdata_i, ctl_i.dpull_k);
    if (ctl_i.flag_clr) begin
      bits_d.flag = bits_q.flag & ~wdata_i;
    end
    // flag latches whatever the mask bit, mask only gates irq
    if (ctl_i.tick) begin
      bits_d.flag = bits_q.flag | (hit & bits_q.intr);
      bits_d.lvl  = level_i;
    end
    if (!en_i) begin
      bits_d = bits_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_q <= '{lvl: 1'b0, intr: 1'b0, mask: 1'b1, pat1: 1'b1, pat0: 1'b0,
                  flag: 1'b0, dpull: 1'b0};
    end else begin
      bits_q <= bits_d;
    end
  end

  // pin outputs reflect the state after this word
  always_comb begin
    pin_o.drv_en  = ~bits_d.intr & bits_d.mask & ~bits_d.pat1;
    pin_o.drv_val = bits_d.pat0 & pin_o.drv_en;
    pin_o.pull_en = ~bits_d.dpull;
    pin_o.irq     = bits_d.flag & bits_d.intr & ~bits_d.mask;
  end

  assign cur_o = bits_q;

endmodule

// ----- src/gpio_merge.sv -----
// gpio_merge: gathers the pin lanes into port words, read select, irq reduction
// and the output register; depends on gpio_pkg and gpio_rsp_if
module gpio_merge #(
  parameter int unsigned NUM_PINS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 acc_i,
  input  gpio_pkg::rd_sel_e    rd_sel_i,
  input  gpio_pkg::gpio_bits_t cur_i [NUM_PINS],
  input  gpio_pkg::gpio_pin_t  pin_i [NUM_PINS],
  output logic                 ready_o,
  gpio_rsp_if.source           rsp_o
);
  import gpio_pkg::*;

  logic [PORT_W-1:0] lvl_v, int_v, mask_v, pat1_v, pat0_v, flag_v, dpull_v;
  logic [PORT_W-1:0] drv_val_v, drv_en_v, pull_v, irq_v;
  logic [PORT_W-1:0] rd;

  logic              valid_q, valid_d;
  logic [PORT_W-1:0] rd_q, drv_val_q, drv_en_q, pull_q;
  logic              irq_q;

  always_comb begin
    lvl_v = '0; int_v = '0; mask_v = '0; pat1_v = '0; pat0_v = '0; flag_v = '0;
    dpull_v = '0; drv_val_v = '0; drv_en_v = '0; pull_v = '0; irq_v = '0;
    // absent pins stay zero
    for (int i = 0; i < NUM_PINS; i++) begin
      lvl_v[i]     = cur_i[i].lvl;
      int_v[i]     = cur_i[i].intr;
      mask_v[i]    = cur_i[i].mask;
      pat1_v[i]    = cur_i[i].pat1;
      pat0_v[i]    = cur_i[i].pat0;
      flag_v[i]    = cur_i[i].flag;
      dpull_v[i]   = cur_i[i].dpull;
      drv_val_v[i] = pin_i[i].drv_val;
      drv_en_v[i]  = pin_i[i].drv_en;
      pull_v[i]    = pin_i[i].pull_en;
      irq_v[i]     = pin_i[i].irq;
    end
  end

  always_comb begin
    unique case (rd_sel_i)
      RD_PIN:   rd = lvl_v;
      RD_INT:   rd = int_v;
      RD_MASK:  rd = mask_v;
      RD_PAT1:  rd = pat1_v;
      RD_PAT0:  rd = pat0_v;
      RD_FLAG:  rd = flag_v;
      RD_DPULL: rd = dpull_v;
      default:  rd = '0;
    endcase
  end

  assign ready_o = ~valid_q | rsp_o.ready;
  assign valid_d = acc_i | (valid_q & ~rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      rd_q      <= rd;
      drv_val_q <= drv_val_v;
      drv_en_q  <= drv_en_v;
      pull_q    <= pull_v;
      irq_q     <= |irq_v;
    end
  end

  assign rsp_o.valid        = valid_q;
  assign rsp_o.read_data    = rd_q;
  assign rsp_o.drive_value  = drv_val_q;
  assign rsp_o.drive_enable = drv_en_q;
  assign rsp_o.pull_enable  = pull_q;
  assign rsp_o.irq          = irq_q;

endmodule
